>>> src/svoc_pkg.sv
// ----------------------------------------------------------------------------
// svoc_pkg: shared types and constants of the voice allocator
// Sizes of the voice table, event and result layouts, function and pick codes.
// ----------------------------------------------------------------------------
package svoc_pkg;

	localparam int NUM_VOICES = 16;
	localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

	localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(NUM_VOICES - 1);

	typedef enum logic [1:0] {
		FUNC_NOTE_ON  = 2'd0,
		FUNC_NOTE_OFF = 2'd1,
		FUNC_FINISHED = 2'd2,
		FUNC_UNUSED   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_FREE = 2'd0,
		KIND_SAME = 2'd1,
		KIND_REL  = 2'd2,
		KIND_HELD = 2'd3
	} kind_t;

	typedef struct packed {
		func_t       func;
		logic [3:0]  channel_id;
		logic [6:0]  note_number;
		logic [31:0] timestamp;
		logic [3:0]  finished_voice;
	} event_t;

	// One entry of the voice table memory
	typedef struct packed {
		logic [31:0] start;
		logic [3:0]  channel;
		logic [6:0]  note;
	} voice_rec_t;

	typedef struct packed {
		logic [3:0] voice_index;
		logic       found;
		kind_t      pick_kind;
	} result_t;

endpackage

>>> src/svoc_ram.sv
// ----------------------------------------------------------------------------
// svoc_ram: simple dual-port synchronous RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module svoc_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> src/svoc_engine.sv
// ----------------------------------------------------------------------------
// svoc_engine: voice table scan and update
// Reads every voice once per note on or off event, keeps running candidates,
// then writes back a note on's pick and updates the active and held flags.
// ----------------------------------------------------------------------------
module svoc_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  svoc_pkg::event_t   ev,
	output logic               idle,
	output logic               res_valid,
	input  logic               res_ready,
	output svoc_pkg::result_t  res
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_DECIDE
	} state_t;

	state_t                               state_q;
	svoc_pkg::event_t                     ev_q;
	logic [svoc_pkg::VIDX_W-1:0]          cnt_q;
	logic                                 rd_v_s1;
	logic [svoc_pkg::VIDX_W-1:0]          idx_s1;
	logic [svoc_pkg::NUM_VOICES-1:0]      active_q;
	logic [svoc_pkg::NUM_VOICES-1:0]      held_q;

	// running candidates
	logic                                 free_hit_q, same_hit_q, rel_hit_q, all_hit_q, off_hit_q;
	logic [svoc_pkg::VIDX_W-1:0]          free_idx_q, same_idx_q, rel_idx_q, all_idx_q, off_idx_q;
	logic [31:0]                          rel_t_q, all_t_q;

	svoc_pkg::voice_rec_t                 rd_data;
	svoc_pkg::voice_rec_t                 wr_data;
	logic                                 wr_en;
	logic                                 rd_en;

	logic                                 ent_active, ent_held, ent_match;
	logic                                 older_rel, older_all;
	logic [svoc_pkg::VIDX_W-1:0]          pick;
	logic [svoc_pkg::VIDX_W-1:0]          fv_idx;
	logic                                 fv_in_range;
	logic                                 commit;

	svoc_ram #(
		.DEPTH (svoc_pkg::NUM_VOICES),
		.WIDTH ($bits(svoc_pkg::voice_rec_t))
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (pick),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (cnt_q),
		.rd_data (rd_data)
	);

	assign rd_en = (state_q == ST_SCAN);

	// evaluate the entry whose read data is arriving
	assign ent_active = active_q[idx_s1];
	assign ent_held   = held_q[idx_s1];
	assign ent_match  = (rd_data.note == ev_q.note_number) &&
	                    (rd_data.channel == ev_q.channel_id);
	// ties go to the later (higher) index
	assign older_rel  = !rel_hit_q || (rd_data.start <= rel_t_q);
	assign older_all  = !all_hit_q || (rd_data.start <= all_t_q);

	assign fv_idx      = svoc_pkg::VIDX_W'(ev_q.finished_voice);
	assign fv_in_range = (32'(ev_q.finished_voice) < 32'(svoc_pkg::NUM_VOICES));

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DECIDE);
	assign commit    = res_valid && res_ready;

	always_comb begin
		pick            = all_idx_q;
		res.voice_index = 4'd0;
		res.found       = 1'b0;
		res.pick_kind   = svoc_pkg::KIND_FREE;
		case (ev_q.func)
			svoc_pkg::FUNC_NOTE_ON: begin
				if (free_hit_q) begin
					pick          = free_idx_q;
					res.pick_kind = svoc_pkg::KIND_FREE;
				end else if (same_hit_q) begin
					pick          = same_idx_q;
					res.pick_kind = svoc_pkg::KIND_SAME;
				end else if (rel_hit_q) begin
					pick          = rel_idx_q;
					res.pick_kind = svoc_pkg::KIND_REL;
				end else begin
					pick          = all_idx_q;
					res.pick_kind = svoc_pkg::KIND_HELD;
				end
				res.voice_index = 4'(pick);
				res.found       = 1'b1;
			end
			svoc_pkg::FUNC_NOTE_OFF: begin
				if (off_hit_q) begin
					res.voice_index = 4'(off_idx_q);
					res.found       = 1'b1;
				end
			end
			svoc_pkg::FUNC_FINISHED: begin
				res.voice_index = ev_q.finished_voice;
			end
			default: begin
				res.voice_index = 4'd0;
			end
		endcase
	end

	assign wr_en         = commit && (ev_q.func == svoc_pkg::FUNC_NOTE_ON);
	assign wr_data.start   = ev_q.timestamp;
	assign wr_data.channel = ev_q.channel_id;
	assign wr_data.note    = ev_q.note_number;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_v_s1    <= 1'b0;
			active_q   <= '0;
			held_q     <= '0;
			free_hit_q <= 1'b0;
			same_hit_q <= 1'b0;
			rel_hit_q  <= 1'b0;
			all_hit_q  <= 1'b0;
			off_hit_q  <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						free_hit_q <= 1'b0;
						same_hit_q <= 1'b0;
						rel_hit_q  <= 1'b0;
						all_hit_q  <= 1'b0;
						off_hit_q  <= 1'b0;
						if (ev.func == svoc_pkg::FUNC_NOTE_ON ||
						    ev.func == svoc_pkg::FUNC_NOTE_OFF) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_SCAN: begin
					if (cnt_q == svoc_pkg::LAST_VOICE) begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
						case (ev_q.func)
							svoc_pkg::FUNC_NOTE_ON: begin
								active_q[pick] <= 1'b1;
								held_q[pick]   <= 1'b1;
							end
							svoc_pkg::FUNC_NOTE_OFF: begin
								if (off_hit_q) begin
									held_q[off_idx_q] <= 1'b0;
								end
							end
							svoc_pkg::FUNC_FINISHED: begin
								if (fv_in_range) begin
									active_q[fv_idx] <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (rd_v_s1) begin
				if (!free_hit_q && !ent_active) begin
					free_hit_q <= 1'b1;
				end
				if (!same_hit_q && !ent_held && ent_match) begin
					same_hit_q <= 1'b1;
				end
				if (!ent_held && older_rel) begin
					rel_hit_q <= 1'b1;
				end
				all_hit_q <= 1'b1;
				if (!off_hit_q && ent_active && ent_held && ent_match) begin
					off_hit_q <= 1'b1;
				end
			end
		end
	end

	// payload: event copy, scan address and candidate indexes and times
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			ev_q  <= ev;
			cnt_q <= '0;
		end else if (state_q == ST_SCAN) begin
			cnt_q <= svoc_pkg::VIDX_W'(cnt_q + 1'b1);
		end
		idx_s1 <= cnt_q;
		if (rd_v_s1) begin
			if (!free_hit_q && !ent_active) begin
				free_idx_q <= idx_s1;
			end
			if (!same_hit_q && !ent_held && ent_match) begin
				same_idx_q <= idx_s1;
			end
			if (!ent_held && older_rel) begin
				rel_idx_q <= idx_s1;
				rel_t_q   <= rd_data.start;
			end
			if (older_all) begin
				all_idx_q <= idx_s1;
				all_t_q   <= rd_data.start;
			end
			if (!off_hit_q && ent_active && ent_held && ent_match) begin
				off_idx_q <= idx_s1;
			end
		end
	end

endmodule

>>> src/synth_voice_allocator.sv
// ----------------------------------------------------------------------------
// synth_voice_allocator: polyphonic voice allocation with voice stealing
// Stream-in note events, stream-out one voice decision per event.
// ----------------------------------------------------------------------------
// Each input transaction is a note event: note on, note off or voice finished
// (tuser selects which). Note on takes the lowest-index free voice; when every
// voice is busy it reuses a released voice of the same channel and note, then
// steals the oldest released voice, then the oldest voice of all (smallest
// start time, ties to the highest index). Note off releases the lowest-index
// held voice that matches channel and note. Voice finished frees the voice
// named in the event. Every event yields exactly one output transaction.
// Note on and note off walk the whole voice table through the table memory
// read port, one voice per cycle; voice finished and the unused code go
// straight to the decision. One event is in work at a time.
// The result sits in an output register, so a new event is accepted while the
// previous result still waits for the downstream side.
// ----------------------------------------------------------------------------
module synth_voice_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [3:0] channel_id, [10:4] note_number, [42:11] timestamp,
	// [46:43] finished_voice, [47] zero
	input  logic [47:0] s_axis_tdata,
	// [1:0] func
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [3:0] voice_index, [7:4] zero
	output logic [7:0]  m_axis_tdata,
	// [0] found, [2:1] pick_kind
	output logic [2:0]  m_axis_tuser
);

	svoc_pkg::event_t  ev;
	svoc_pkg::result_t eng_res;
	svoc_pkg::result_t res_q;
	logic              eng_idle;
	logic              eng_res_valid;
	logic              res_ready;
	logic              out_valid_q;
	logic              in_xfer;

	// unpack the input transaction
	assign ev.func           = svoc_pkg::func_t'(s_axis_tuser);
	assign ev.channel_id     = s_axis_tdata[3:0];
	assign ev.note_number    = s_axis_tdata[10:4];
	assign ev.timestamp      = s_axis_tdata[42:11];
	assign ev.finished_voice = s_axis_tdata[46:43];

	// accept only while the engine has no event in work
	assign s_axis_tready = eng_idle;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// the engine may hand over a result once the output register is free
	// or being emptied this cycle
	assign res_ready = !out_valid_q || m_axis_tready;

	svoc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_xfer),
		.ev        (ev),
		.idle      (eng_idle),
		.res_valid (eng_res_valid),
		.res_ready (res_ready),
		.res       (eng_res)
	);

	// output register: hold the result until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_res_valid && res_ready) begin
			res_q <= eng_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, res_q.voice_index};
	assign m_axis_tuser  = {res_q.pick_kind, res_q.found};

endmodule

>>> src/svoc_checker.sv
// ----------------------------------------------------------------------------
// svoc_checker: port-level checks for the voice allocator
// Watches both stream sides and the result fields over time.
// ----------------------------------------------------------------------------
module svoc_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic [2:0]  m_axis_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tuser))
		else $error("stalled result changed");

	// one event in work: no acceptance right after one
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while an event is in work");

	// an event's result never rises straight after its acceptance
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("result appeared too early");

	// a result without a found voice never reports a pick rule
	a_kind_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tuser[2:1] == 2'd0)
		else $error("pick kind set without a found voice");

endmodule

bind synth_voice_allocator svoc_port_checker u_svoc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

>>> bench/svoc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// svoc_checker: voice decision scoreboard for the voice allocator
// Mirrors the voice table from every accepted note event, queues the decision
// each event should produce and compares each output transaction against it.
// ----------------------------------------------------------------------------
module svoc_checker
	import svoc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,
	input  logic [2:0]  m_axis_tuser,
	output int unsigned mismatches,
	output int unsigned pending
);

	logic        active_tbl [NUM_VOICES];
	logic        held_tbl   [NUM_VOICES];
	logic [6:0]  note_tbl   [NUM_VOICES];
	logic [3:0]  chan_tbl   [NUM_VOICES];
	logic [31:0] start_tbl  [NUM_VOICES];

	result_t     decision_q [$];
	result_t     want_r;
	result_t     got_r;
	int unsigned miss_cnt = 0;

	// Smallest start time wins, ties go to the highest index.
	function automatic int oldest_voice_idx(bit released_only);
		int          best = -1;
		logic [31:0] best_t = '0;
		for (int i = 0; i < NUM_VOICES; i++) begin
			if (!released_only || !held_tbl[i]) begin
				if (best < 0 || start_tbl[i] <= best_t) begin
					best   = i;
					best_t = start_tbl[i];
				end
			end
		end
		return best;
	endfunction

	// Apply one note event to the mirrored table and return its decision.
	function automatic result_t decide_voice(func_t fn, logic [3:0] ch, logic [6:0] nt,
			logic [31:0] ts, logic [3:0] fv);
		result_t r;
		int      pick;
		r    = '0;
		pick = -1;
		case (fn)
			FUNC_NOTE_ON: begin
				for (int i = 0; i < NUM_VOICES; i++)
					if (pick < 0 && !active_tbl[i])
						pick = i;
				r.pick_kind = KIND_FREE;
				if (pick < 0) begin
					for (int i = 0; i < NUM_VOICES; i++)
						if (pick < 0 && !held_tbl[i] && note_tbl[i] == nt && chan_tbl[i] == ch)
							pick = i;
					r.pick_kind = KIND_SAME;
				end
				if (pick < 0) begin
					pick        = oldest_voice_idx(1'b1);
					r.pick_kind = KIND_REL;
				end
				if (pick < 0) begin
					pick        = oldest_voice_idx(1'b0);
					r.pick_kind = KIND_HELD;
				end
				active_tbl[pick] = 1'b1;
				held_tbl[pick]   = 1'b1;
				note_tbl[pick]   = nt;
				chan_tbl[pick]   = ch;
				start_tbl[pick]  = ts;
				r.voice_index    = 4'(pick);
				r.found          = 1'b1;
			end
			FUNC_NOTE_OFF: begin
				// release only the lowest matching held voice
				for (int i = 0; i < NUM_VOICES; i++) begin
					if (!r.found && active_tbl[i] && held_tbl[i] &&
							chan_tbl[i] == ch && note_tbl[i] == nt) begin
						held_tbl[i]   = 1'b0;
						r.voice_index = 4'(i);
						r.found       = 1'b1;
					end
				end
			end
			FUNC_FINISHED: begin
				if (int'(fv) < NUM_VOICES)
					active_tbl[fv] = 1'b0;
				r.voice_index = fv;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VOICES; i++) begin
				active_tbl[i] = 1'b0;
				held_tbl[i]   = 1'b0;
				note_tbl[i]   = '0;
				chan_tbl[i]   = '0;
				start_tbl[i]  = '0;
			end
			decision_q.delete();
			pending    <= 0;
			mismatches <= miss_cnt;
		end else begin
			// retire before predicting so a result never meets its own event
			if (m_axis_tvalid && m_axis_tready) begin
				got_r.voice_index = m_axis_tdata[3:0];
				got_r.found       = m_axis_tuser[0];
				got_r.pick_kind   = kind_t'(m_axis_tuser[2:1]);
				if (decision_q.size() == 0) begin
					miss_cnt++;
					if (miss_cnt <= 10)
						$display("%0t: unexpected decision voice %0d found %0d kind %0d",
							$time, got_r.voice_index, got_r.found, got_r.pick_kind);
				end else begin
					want_r = decision_q.pop_front();
					if (got_r.voice_index !== want_r.voice_index ||
							got_r.found !== want_r.found ||
							got_r.pick_kind !== want_r.pick_kind) begin
						miss_cnt++;
						if (miss_cnt <= 10)
							$display("%0t: decision mismatch: voice %0d/%0d found %0d/%0d kind %0d/%0d (exp/got)",
								$time, want_r.voice_index, got_r.voice_index,
								want_r.found, got_r.found, want_r.pick_kind, got_r.pick_kind);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				decision_q.push_back(decide_voice(func_t'(s_axis_tuser), s_axis_tdata[3:0],
					s_axis_tdata[10:4], s_axis_tdata[42:11], s_axis_tdata[46:43]));
			pending    <= decision_q.size();
			mismatches <= miss_cnt;
		end
	end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: note event stimulus and verdict for the voice allocator
// Drives a directed sweep through every allocation rule, then random note
// traffic with bursty idling on both streams; svoc_checker scores results.
// ----------------------------------------------------------------------------
module testbench;
	import svoc_pkg::*;

	localparam int RANDOM_EVENTS = 800;
	// the tail of the random part runs without any idling
	localparam int CALM_EVENTS   = 100;
	// cycles without any transaction before the run is declared hung
	localparam int STALL_LIMIT   = 2000;
	// one full table walk plus margin, for stray results after the drain
	localparam int DRAIN_CYCLES  = NUM_VOICES + 8;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata  = '0;
	logic [1:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	int unsigned mismatches;
	int unsigned pending;

	// Percent chance of a sender gap per event; the receiver derives its
	// per-cycle stall chance from it. Re-rolled every 50 random events so
	// that some stretches carry no idling at all.
	int          idle_pct     = 10;
	bit          calm         = 1'b0;
	int          rx_hold      = 0;
	int          quiet_cycles = 0;
	logic [31:0] now_ts       = '0;

	// recent note-on pairs, so most note offs hit a held voice
	logic [3:0]  recent_ch [$];
	logic [6:0]  recent_nt [$];

	always #5 clk = ~clk;

	synth_voice_allocator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	svoc_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	// Downstream side: hold tready low for bursts of random length.
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold       <= rx_hold - 1;
		end else if (!calm && $urandom_range(0, 399) < idle_pct) begin
			m_axis_tready <= 1'b0;
			rx_hold       <= $urandom_range(0, 18);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Watchdog: end the run once no transaction has moved for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one note event, optionally after an idle gap, and wait for the
	// transaction. tvalid is left high so a following event can take over
	// in the same step with a single assignment.
	task automatic push_event(func_t fn, logic [3:0] ch, logic [6:0] nt,
			logic [31:0] ts, logic [3:0] fv);
		if (!calm && $urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, fv, ts, nt, ch};
		s_axis_tuser  <= fn;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (fn == FUNC_NOTE_ON) begin
			recent_ch.push_back(ch);
			recent_nt.push_back(nt);
			if (recent_ch.size() > 24) begin
				void'(recent_ch.pop_front());
				void'(recent_nt.pop_front());
			end
		end
	endtask

	initial begin
		int          sel;
		int          pick;
		func_t       fn;
		logic [3:0]  ch;
		logic [6:0]  nt;
		logic [31:0] ts;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sweep. Fill from empty, release and match, free a voice,
		// then exhaust the table to reach reuse and both stealing rules.
		push_event(FUNC_NOTE_ON,  4'd0,  7'd0,   32'd0,          4'd0);
		push_event(FUNC_NOTE_ON,  4'd15, 7'd127, 32'hFFFF_FFFF,  4'd0);
		push_event(FUNC_NOTE_OFF, 4'd15, 7'd127, 32'd0,          4'd0);
		// note off with no matching held voice
		push_event(FUNC_NOTE_OFF, 4'd3,  7'd5,   32'd0,          4'd0);
		push_event(FUNC_FINISHED, 4'd0,  7'd0,   32'd0,          4'd1);
		// finishing a voice that is already idle
		push_event(FUNC_FINISHED, 4'd0,  7'd0,   32'd0,          4'd15);
		// unused selector with every field at its top value
		push_event(FUNC_UNUSED,   4'hF,  7'h7F,  32'hFFFF_FFFF,  4'hF);
		// occupy the rest of the table with equal start times
		for (int v = 1; v < NUM_VOICES; v++)
			push_event(FUNC_NOTE_ON, 4'd1, 7'd10, 32'd100, 4'd0);
		// all held, none released: steal the oldest held voice
		push_event(FUNC_NOTE_ON,  4'd1,  7'd20,  32'd200,        4'd0);
		push_event(FUNC_NOTE_OFF, 4'd1,  7'd10,  32'd0,          4'd0);
		// released voice with the same channel and note is reused
		push_event(FUNC_NOTE_ON,  4'd1,  7'd10,  32'd300,        4'd0);
		push_event(FUNC_NOTE_OFF, 4'd1,  7'd10,  32'd0,          4'd0);
		push_event(FUNC_NOTE_OFF, 4'd1,  7'd10,  32'd0,          4'd0);
		// new note: steal the oldest released voice
		push_event(FUNC_NOTE_ON,  4'd4,  7'd4,   32'd5,          4'd0);

		// Random traffic: mostly a small pool of channels and notes so voices
		// collide, timestamps mixing full range, tight ties and slow growth.
		for (int n = 0; n < RANDOM_EVENTS; n++) begin
			if (n % 50 == 0) begin
				case ($urandom_range(0, 2))
					0:       idle_pct = 0;
					1:       idle_pct = 10;
					default: idle_pct = 40;
				endcase
			end
			calm = (n >= RANDOM_EVENTS - CALM_EVENTS);

			ch = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
			nt = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'(60 + $urandom_range(0, 3));
			case ($urandom_range(0, 2))
				0: ts = $urandom;
				1: ts = 32'($urandom_range(0, 7));
				default: begin
					now_ts = now_ts + $urandom_range(0, 2);
					ts     = now_ts;
				end
			endcase

			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				fn = FUNC_NOTE_ON;
			end else if (sel < 75) begin
				fn = FUNC_NOTE_OFF;
				if (recent_ch.size() > 0 && $urandom_range(0, 9) < 8) begin
					pick = $urandom_range(0, recent_ch.size() - 1);
					ch   = recent_ch[pick];
					nt   = recent_nt[pick];
				end
			end else if (sel < 95) begin
				fn = FUNC_FINISHED;
			end else begin
				fn = FUNC_UNUSED;
			end
			push_event(fn, ch, nt, ts, 4'($urandom));
		end
		s_axis_tvalid <= 1'b0;

		// drain: pending is registered, so it is read only once the clock has updated it
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> files.f
src/svoc_pkg.sv
src/svoc_ram.sv
src/svoc_engine.sv
src/synth_voice_allocator.sv
src/svoc_checker.sv
bench/svoc_checker.sv
bench/testbench.sv
